// ----- rtl/ase_pkg.sv -----
// Shared constants and types for the ascending sort engine.
// No dependencies; every other file of the block uses this package.
package ase_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int VALUE_W   = 32;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

   // Control outputs of the sequencer toward the chain and the channels.
   typedef struct packed {
      logic req_ready;
      logic rsp_valid;
      logic rsp_last;
      logic overflow;
      logic insert;
      logic shift;
   } ctl_type;

endpackage

// ----- rtl/ase_if.sv -----
// Handshake channel interfaces for the ascending sort engine.
// Depends on ase_pkg for the value width.
interface ase_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ase_pkg::VALUE_W-1:0]   in_value;
   logic                                 in_last;

   modport source (output valid, output in_value, output in_last, input ready);
   modport sink   (input valid, input in_value, input in_last, output ready);
endinterface

interface ase_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ase_pkg::VALUE_W-1:0]   out_value;
   logic                                 out_last;
   logic                                 overflow;

   modport source (output valid, output out_value, output out_last, output overflow,
                   input ready);
   modport sink   (input valid, input out_value, input out_last, input overflow,
                   output ready);
endinterface

// ----- rtl/ase_cell.sv -----
// One cell of the systolic insertion chain: holds one value, passes the larger on.
// Depends on ase_pkg.
module ase_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift,
   input  logic                                pass_in_valid,
   input  logic signed [ase_pkg::VALUE_W-1:0]  pass_in_value,
   input  logic                                right_valid,
   input  logic signed [ase_pkg::VALUE_W-1:0]  right_value,
   output logic                                pass_out_valid,
   output logic signed [ase_pkg::VALUE_W-1:0]  pass_out_value,
   output logic                                held_valid,
   output logic signed [ase_pkg::VALUE_W-1:0]  held_value
);
   import ase_pkg::*;

   logic                       held_valid_ff, held_valid_in;
   logic signed [VALUE_W-1:0]  held_value_ff, held_value_in;
   logic                       pass_valid_ff, pass_valid_in;
   logic signed [VALUE_W-1:0]  pass_value_ff, pass_value_in;
   logic                       in_smaller;

   assign in_smaller = pass_in_value < held_value_ff;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      pass_valid_in = 1'b0;
      pass_value_in = pass_value_ff;
      if (shift) begin
         // Drain: the whole row moves one place toward the head.
         held_valid_in = right_valid;
         held_value_in = right_value;
      end else if (pass_in_valid) begin
         if (!held_valid_ff) begin
            held_valid_in = 1'b1;
            held_value_in = pass_in_value;
         end else if (in_smaller) begin
            held_value_in = pass_in_value;
            pass_valid_in = 1'b1;
            pass_value_in = held_value_ff;
         end else begin
            pass_valid_in = 1'b1;
            pass_value_in = pass_in_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         pass_valid_ff <= pass_valid_in;
      end
      held_value_ff <= held_value_in;
      pass_value_ff <= pass_value_in;
   end

   assign pass_out_valid = pass_valid_ff;
   assign pass_out_value = pass_value_ff;
   assign held_valid     = held_valid_ff;
   assign held_value     = held_value_ff;

endmodule

// ----- rtl/ase_ctrl.sv -----
// Sequencer of the sort engine: counts held items, waits for the chain to settle,
// then paces the drain. Depends on ase_pkg.
module ase_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   input  logic             rsp_ready,
   output ase_pkg::ctl_type ctl
);
   import ase_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] settle_ff, settle_in;
   logic             drop_ff, drop_in;
   logic             req_fire, rsp_fire, full, settled;

   assign full     = count_ff == CNT_W'(MAX_ITEMS);
   assign settled  = settle_ff == CNT_W'(MAX_ITEMS - 1);
   assign req_fire = req_valid && ctl.req_ready;
   assign rsp_fire = ctl.rsp_valid && rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:   if (req_fire && req_last) state_in = ST_SETTLE;
         ST_SETTLE: if (settled) state_in = ST_DRAIN;
         ST_DRAIN:  if (rsp_fire && count_ff == CNT_W'(1)) state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   // Outputs.
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         ST_LOAD: begin
            ctl.req_ready = 1'b1;
            ctl.insert    = req_valid && !full;
         end
         ST_DRAIN: begin
            ctl.rsp_valid = 1'b1;
            ctl.rsp_last  = count_ff == CNT_W'(1);
            ctl.shift     = rsp_ready;
         end
         default: ;
      endcase
      ctl.overflow = drop_ff;
   end

   // Counters and the dropped flag.
   always_comb begin
      count_in  = count_ff;
      settle_in = '0;
      drop_in   = drop_ff;
      if (req_fire) begin
         if (full) drop_in = 1'b1;
         else      count_in = count_ff + CNT_W'(1);
      end
      if (state_ff == ST_SETTLE) settle_in = settle_ff + CNT_W'(1);
      if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) drop_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         settle_ff <= '0;
         drop_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         settle_ff <= settle_in;
         drop_ff   <= drop_in;
      end
   end

endmodule

// ----- rtl/ascending_sort_engine_top.sv -----
// Top level of the ascending sort engine: sequencer plus a row of insertion cells.
// Depends on ase_pkg, ase_if, ase_cell and ase_ctrl.
//
//   channel  direction  handshake        payload
//   req      in         valid / ready    in_value, in_last
//   rsp      out        valid / ready    out_value, out_last, overflow
//
// Load: one item per cycle while loading; each value ripples down the cell row one cell a cycle.
// After the item marked last, the row settles, then the results drain one per cycle
// from the head cell while the sink is ready. req_ready is low from the last item
// until the final result. A stalled result holds, since the row shifts only when a
// result is taken.
// Reset is synchronous and empties the row.
module ascending_sort_engine_top (
   input logic   clock,
   input logic   reset,
   ase_req_if.sink   req,
   ase_rsp_if.source rsp
);
   import ase_pkg::*;

   ctl_type                   ctl;
   logic                      pass_valid [0:MAX_ITEMS];
   logic signed [VALUE_W-1:0] pass_value [0:MAX_ITEMS];
   logic                      held_valid [0:MAX_ITEMS];
   logic signed [VALUE_W-1:0] held_value [0:MAX_ITEMS];

   ase_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (req.in_last),
      .rsp_ready (rsp.ready),
      .ctl       (ctl)
   );

   assign pass_valid[0]         = ctl.insert;
   assign pass_value[0]         = req.in_value;
   assign held_valid[MAX_ITEMS] = 1'b0;
   assign held_value[MAX_ITEMS] = '0;

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      ase_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .shift          (ctl.shift),
         .pass_in_valid  (pass_valid[i]),
         .pass_in_value  (pass_value[i]),
         .right_valid    (held_valid[i+1]),
         .right_value    (held_value[i+1]),
         .pass_out_valid (pass_valid[i+1]),
         .pass_out_value (pass_value[i+1]),
         .held_valid     (held_valid[i]),
         .held_value     (held_value[i])
      );
   end

   assign req.ready     = ctl.req_ready;
   assign rsp.valid     = ctl.rsp_valid;
   assign rsp.out_value = held_value[0];
   assign rsp.out_last  = ctl.rsp_last;
   assign rsp.overflow  = ctl.overflow;

endmodule

// ----- rtl/ase_checker.sv -----
// Port-level checker for the ascending sort engine, bound to the top level.
// Depends on ase_pkg and on the top level's interface ports.
module ase_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ase_pkg::VALUE_W-1:0]  rsp_value,
   input logic                                rsp_last,
   input logic                                rsp_overflow
);
   import ase_pkg::*;

   logic rsp_fire;
   assign rsp_fire = rsp_valid && rsp_ready;

   // A result that waits keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_last)
         && $stable(rsp_overflow))
      else $error("result changed while stalled");

   // Loading and draining never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while results pending");

   // Results of one set come out in ascending order, back to back in the drain.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> rsp_valid && rsp_value >= $past(rsp_value))
      else $error("results out of order");

   // The overflow mark is the same on every result of a set.
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> rsp_overflow == $past(rsp_overflow))
      else $error("overflow changed within a set");

   // After the final result the block goes back to loading.
   a_set_end: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_last |=> !rsp_valid && req_ready)
      else $error("block did not return to loading");

endmodule

bind ascending_sort_engine_top ase_checker u_ase_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_value    (rsp.out_value),
   .rsp_last     (rsp.out_last),
   .rsp_overflow (rsp.overflow)
);

// ----- bench/tb_ascending_sort_engine_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for ascending_sort_engine_top: drives sets of signed values and
// checks that every sorted result and its flags come out in order.
// Depends on ase_pkg, ase_if and the RTL of the engine.
module tb_ascending_sort_engine_top;
   import ase_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_WAIT   = MAX_ITEMS + 16;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef struct {
      value_type value;
      logic      last;
      logic      overflow;
   } sorted_result_type;

   // Keeps the open set in ascending order as items arrive and releases the
   // whole sorted set as expected results when the marked item comes.
   class sort_scoreboard;
      value_type         held[MAX_ITEMS];
      int                held_n = 0;
      bit                dropped = 0;
      sorted_result_type sorted_q[$];
      int                mismatches = 0;

      function void note_value(value_type v, logic last);
         int                pos;
         sorted_result_type r;
         if (held_n < MAX_ITEMS) begin
            pos = held_n;
            while (pos > 0 && held[pos-1] > v) begin
               held[pos] = held[pos-1];
               pos--;
            end
            held[pos] = v;
            held_n++;
         end else begin
            dropped = 1'b1;
         end
         if (last) begin
            for (int k = 0; k < held_n; k++) begin
               r.value    = held[k];
               r.last     = (k == held_n - 1);
               r.overflow = dropped;
               sorted_q.push_back(r);
            end
            held_n  = 0;
            dropped = 1'b0;
         end
      endfunction

      function void check_result(value_type v, logic last, logic ovf);
         sorted_result_type r;
         if (sorted_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %0d last %b overflow %b", v, last, ovf);
            return;
         end
         r = sorted_q.pop_front();
         if (v !== r.value || last !== r.last || ovf !== r.overflow) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result differs: expected %0d/%b/%b, got %0d/%b/%b",
                        r.value, r.last, r.overflow, v, last, ovf);
         end
      endfunction

      function int pending();
         return sorted_q.size() + held_n;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on;
   int   cycles;
   sort_scoreboard sb;

   ase_req_if req_bus();
   ase_rsp_if rsp_bus();

   ascending_sort_engine_top uut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("ascending_sort_engine_top: mismatch");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Full-range values, with extremes and a narrow band that forces duplicates.
   function value_type random_value();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // Most sets are small; a few reach or pass the store size.
   function int pick_set_size();
      case ($urandom_range(0, 19))
         0: return MAX_ITEMS + $urandom_range(0, 4);
         1: return $urandom_range(MAX_ITEMS / 2, MAX_ITEMS - 1);
         default: return $urandom_range(1, 10);
      endcase
   endfunction

   task send_item(input value_type v, input logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_value <= v;
      req_bus.in_last  <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task watch_requests();
      forever begin
         @(posedge clock);
         if (!reset && req_bus.valid && req_bus.ready)
            sb.note_value(req_bus.in_value, req_bus.in_last);
      end
   endtask

   task run_sink();
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_result(rsp_bus.out_value, rsp_bus.out_last, rsp_bus.overflow);
         if (stall_left > 0)
            stall_left--;
         else if (idle_on && $urandom_range(0, 99) < 12)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         rsp_bus.ready <= (stall_left == 0);
      end
   endtask

   initial begin
      value_type mixed[11];
      int        set_size;
      int        set_count;
      int        random_sent;

      mixed = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1, 32'sd1, 32'sd0,
                -32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1234_5678, -32'sd2};
      clock            = 1'b0;
      reset            = 1'b1;
      idle_on          = 1'b0;
      cycles           = 0;
      req_bus.valid    = 1'b0;
      req_bus.in_value = '0;
      req_bus.in_last  = 1'b0;
      rsp_bus.ready    = 1'b0;
      sb               = new;
      fork
         watch_requests();
         run_sink();
      join_none

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Single-item sets at both ends of the range.
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sh7FFF_FFFF, 1'b1);
      // Extremes and duplicates in scrambled order, with both sides idling.
      idle_on = 1'b1;
      for (int i = 0; i < 11; i++)
         send_item(mixed[i], i == 10);
      // Already ascending, then descending.
      for (int i = 0; i < 5; i++)
         send_item(i - 2, i == 4);
      for (int i = 0; i < 5; i++)
         send_item(2 - i, i == 4);

      // The first two random sets overflow the store and fill it exactly.
      set_count   = 0;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (set_count == 0)
            set_size = MAX_ITEMS + 2;
         else if (set_count == 1)
            set_size = MAX_ITEMS;
         else
            set_size = pick_set_size();
         idle_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < set_size; i++)
            send_item(random_value(), i == set_size - 1);
         random_sent += set_size;
         set_count++;
      end
      req_bus.valid <= 1'b0;
      idle_on = 1'b1;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0)
         $display("ascending_sort_engine_top: match");
      else
         $display("ascending_sort_engine_top: mismatch");
      $finish;
   end

endmodule
